FILE: hw/rtl/ifs_pkg.sv
// Package for the integer field scanner.
// Holds character codes, status codes, the phase type and the digit decode.
// No dependencies.
package ifs_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned WIDTH_W  = 9;
    localparam int unsigned CFG_W    = 9;
    localparam int unsigned STATUS_W = 2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] NOT_DIGIT  = 8'hFF;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    typedef enum logic {
        REG_NUMBER_BASE = 1'b0,
        REG_FIELD_WIDTH = 1'b1
    } reg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_DIGITS = 2'd1,
        STATUS_NO_FIELD  = 2'd2
    } status_t;

    typedef enum logic {
        PH_SKIP  = 1'b0,
        PH_FIELD = 1'b1
    } phase_t;

    // Characters past 'f' or 'F' decode to 16 or more; the base compare rejects them.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_LC_A) begin
            d = c - CHAR_LC_A + 8'd10;
        end else if (c >= CHAR_UC_A) begin
            d = c - CHAR_UC_A + 8'd10;
        end else begin
            d = NOT_DIGIT;
        end
        return d;
    endfunction

endpackage

FILE: hw/rtl/integer_field_scanner.sv
// Integer field scanner: top level, single module.
// Depends on ifs_pkg for codes, types and the digit decode.
//
// Takes one character per cycle while s_ready is high and returns one result per integer
// field. An item first lands in an input register; the scan logic (digit decode, one
// shift-add of the accumulator, the sign fix-up) then updates the field state from it
// as it advances and, when the field ends, loads the result register, which drives
// m_valid; a new item is taken in the same cycle as the held one advances. While a
// result waits in the result register, s_ready follows m_ready only for a held item
// that would itself end a field; blanks, signs and inner digits keep flowing.
module integer_field_scanner
    import ifs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata,
    // input items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_code,
    input  logic                       s_end_of_input,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VALUE_W-1:0]  m_value,
    output logic [STATUS_W-1:0]        m_status,
    output logic                       m_char_not_consumed
);

    // configuration registers
    logic [1:0]          base_reg;
    logic [WIDTH_W-1:0]  width_reg;

    // input register
    logic                in_valid_reg;
    logic [7:0]          in_char_reg;
    logic                in_eoi_reg;

    // field state
    phase_t              phase_reg, phase_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic [WIDTH_W-1:0]  left_reg, left_next;
    logic                seen_reg, seen_next;

    // result register
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;
    logic                out_ncons_reg, out_ncons_next;

    logic                emit;
    logic                advance;

    // scan working values
    logic [VALUE_W-1:0]  cur_acc, acc_step;
    logic                cur_neg, cur_seen;
    logic [WIDTH_W-1:0]  cur_left, left_dec;
    logic [7:0]          dval;
    logic [4:0]          radix;
    logic                take, blank;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_DEC;
            width_reg <= WIDTH_W'(256);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NUMBER_BASE: base_reg  <= cfg_wdata[1:0];
                REG_FIELD_WIDTH: width_reg <= cfg_wdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (base_reg)
            BASE_OCT: radix = 5'd8;
            BASE_HEX: radix = 5'd16;
            default:  radix = 5'd10;
        endcase
    end

    always_comb begin
        case (in_char_reg) inside
            CHAR_SPACE, CHAR_TAB, CHAR_NL: blank = 1'b1;
            default:                       blank = 1'b0;
        endcase
    end

    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        left_next       = left_reg;
        seen_next       = seen_reg;
        emit            = 1'b0;
        out_status_next = STATUS_OK;
        out_ncons_next  = 1'b0;

        // a field opened by a non-blank, non-minus character starts fresh here
        if (phase_reg == PH_SKIP) begin
            cur_acc  = '0;
            cur_neg  = 1'b0;
            cur_left = width_reg;
            cur_seen = 1'b0;
        end else begin
            cur_acc  = acc_reg;
            cur_neg  = neg_reg;
            cur_left = left_reg;
            cur_seen = seen_reg;
        end

        dval     = digit_value(in_char_reg);
        take     = (dval < {3'b000, radix}) && (cur_left != '0);
        left_dec = cur_left - WIDTH_W'(1);
        case (base_reg)
            BASE_OCT: acc_step = {cur_acc[VALUE_W-4:0], 3'b000};
            BASE_HEX: acc_step = {cur_acc[VALUE_W-5:0], 4'b0000};
            default:  acc_step = {cur_acc[VALUE_W-4:0], 3'b000}
                                 + {cur_acc[VALUE_W-2:0], 1'b0};
        endcase
        acc_step = acc_step + VALUE_W'(dval[3:0]);

        if (in_valid_reg) begin
            if (in_eoi_reg) begin
                emit = 1'b1;
                if (phase_reg == PH_SKIP) begin
                    out_status_next = STATUS_NO_FIELD;
                end else if (!seen_reg) begin
                    out_status_next = STATUS_NO_DIGITS;
                end
            end else if (phase_reg == PH_SKIP && blank) begin
                emit = 1'b0;
            end else if (phase_reg == PH_SKIP && in_char_reg == CHAR_MINUS) begin
                phase_next = PH_FIELD;
                acc_next   = '0;
                neg_next   = 1'b1;
                left_next  = width_reg;
                seen_next  = 1'b0;
            end else if (take) begin
                phase_next = PH_FIELD;
                acc_next   = acc_step;
                neg_next   = cur_neg;
                left_next  = left_dec;
                seen_next  = 1'b1;
                emit       = (left_dec == '0);
            end else begin
                emit            = 1'b1;
                out_ncons_next  = 1'b1;
                out_status_next = cur_seen ? STATUS_OK : STATUS_NO_DIGITS;
            end
        end

        if (out_status_next != STATUS_OK) begin
            out_value_next = '0;
        end else if (cur_neg) begin
            out_value_next = VALUE_W'(0) - acc_next;
        end else begin
            out_value_next = acc_next;
        end

        if (emit) begin
            phase_next = PH_SKIP;
            acc_next   = '0;
            neg_next   = 1'b0;
            left_next  = '0;
            seen_next  = 1'b0;
        end
    end

    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_eoi_reg  <= s_end_of_input;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            left_reg  <= '0;
            seen_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            left_reg  <= left_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_ncons_reg  <= out_ncons_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_value             = out_value_reg;
    assign m_status            = out_status_reg;
    assign m_char_not_consumed = out_ncons_reg;

    // every result closes the field
    a_result_closes_field: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (phase_reg == PH_SKIP && acc_reg == '0 && !neg_reg))
        else $error("field state not cleared after result");

    // outside a field no digit count or digit flag survives
    a_skip_state_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> (left_reg == '0 && !seen_reg))
        else $error("stale field state while skipping blanks");

    // error results carry a zero value
    a_error_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != STATUS_OK) |-> (out_value_reg == '0))
        else $error("nonzero value on error result");

    // end of input outside a field never hands a character back
    a_no_field_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STATUS_NO_FIELD) |-> !out_ncons_reg)
        else $error("end-of-input result marks a character unconsumed");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(advance && emit))
        else $error("result register overwritten while stalled");

endmodule

FILE: tb/integer_field_scanner_tb.sv
// Self-checking testbench for integer_field_scanner.
// Holds the field predictor/scoreboard class and the stimulus; needs ifs_pkg and the RTL.
`timescale 1ns / 1ps

module integer_field_scanner_tb
    import ifs_pkg::*;
();

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 6;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_ITEMS  = 100;
    localparam int RAND_PHASES  = 8;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
        logic                      not_consumed;
    } field_result_t;

    // Predicts the result of each scanned field and checks the results in order.
    class field_scoreboard;
        logic [1:0]         base_code;
        logic [WIDTH_W-1:0] width_limit;
        phase_t             scan_phase;
        logic [VALUE_W-1:0] acc;
        logic               neg;
        logic [WIDTH_W-1:0] digits_left;
        logic               seen;
        field_result_t      pending_fields[$];
        int                 mismatches;

        function new();
            base_code   = BASE_DEC;
            width_limit = 9'd256;
            mismatches  = 0;
            clear_field();
        endfunction

        function void clear_field();
            scan_phase  = PH_SKIP;
            acc         = '0;
            neg         = 1'b0;
            digits_left = '0;
            seen        = 1'b0;
        endfunction

        function void emit(status_t st, logic nc);
            field_result_t r;
            r.value        = (st == STATUS_OK) ? (neg ? -acc : acc) : '0;
            r.status       = st;
            r.not_consumed = nc;
            pending_fields.push_back(r);
            clear_field();
        endfunction

        function void note_char(logic [7:0] c, logic eoi);
            int unsigned radix_n;
            int unsigned dval;
            if (eoi) begin
                if (scan_phase == PH_SKIP) begin
                    emit(STATUS_NO_FIELD, 1'b0);
                end else begin
                    emit(seen ? STATUS_OK : STATUS_NO_DIGITS, 1'b0);
                end
                return;
            end
            if (scan_phase == PH_SKIP) begin
                if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL) return;
                scan_phase  = PH_FIELD;
                acc         = '0;
                neg         = (c == CHAR_MINUS);
                digits_left = width_limit;
                seen        = 1'b0;
                if (neg) return;
            end
            // base code 3 is unused and scans as decimal
            radix_n = (base_code == BASE_OCT) ? 8 : (base_code == BASE_HEX) ? 16 : 10;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                dval = 32'(c - CHAR_ZERO);
            end else if (c >= CHAR_LC_A) begin
                dval = c - CHAR_LC_A + 10;
            end else if (c >= CHAR_UC_A) begin
                dval = c - CHAR_UC_A + 10;
            end else begin
                dval = 255;
            end
            if (dval < radix_n && digits_left != 0) begin
                acc         = acc * radix_n + dval;
                digits_left = digits_left - 1'b1;
                seen        = 1'b1;
                if (digits_left == 0) emit(STATUS_OK, 1'b0);
            end else begin
                emit(seen ? STATUS_OK : STATUS_NO_DIGITS, 1'b1);
            end
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] v, logic [STATUS_W-1:0] st,
                                   logic nc);
            field_result_t want;
            if (pending_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: value %0d status %0d not_consumed %0b",
                             v, st, nc);
                return;
            end
            want = pending_fields.pop_front();
            if (v !== want.value || st !== want.status || nc !== want.not_consumed) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: exp value %0d st %0d nc %0b, got %0d st %0d nc %0b",
                             want.value, want.status, want.not_consumed, v, st, nc);
            end
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_index = 1'b0;
    logic [CFG_W-1:0]          cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_char_code = '0;
    logic                      s_end_of_input = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_value;
    logic [STATUS_W-1:0]       m_status;
    logic                      m_char_not_consumed;

    field_scoreboard sb = new();
    int              cycle_count = 0;
    int              items_sent;
    bit              s_burst = 1'b0;
    bit              r_burst = 1'b0;

    integer_field_scanner i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_char_code         (s_char_code),
        .s_end_of_input      (s_end_of_input),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_value             (m_value),
        .m_status            (m_status),
        .m_char_not_consumed (m_char_not_consumed)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_field_scanner regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_value, m_status, m_char_not_consumed);
    end

    // result side: random stall before each item, with stretches of none
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) r_burst = !r_burst;
            gap = r_burst ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // called in the time step of a rising edge; returns in the step of the accepting edge
    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
        gap = s_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_code    <= c;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        sb.note_char(c, eoi);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], 1'b0);
    endtask

    // waits out every pending result plus the pipeline, so registers can be written
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_fields.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == REG_NUMBER_BASE) sb.base_code = data[1:0];
        else sb.width_limit = data[WIDTH_W-1:0];
    endtask

    // blanks, optional sign, digits valid in the current base, then an optional terminator
    task automatic send_field();
        int          n_blank;
        int          n_dig;
        int unsigned d;
        logic [7:0]  ch;
        n_blank = $urandom_range(0, 3);
        repeat (n_blank) begin
            case ($urandom_range(0, 2))
                0: ch = CHAR_SPACE;
                1: ch = CHAR_TAB;
                default: ch = CHAR_NL;
            endcase
            send_char(ch, 1'b0);
            items_sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
            send_char(CHAR_MINUS, 1'b0);
            items_sent++;
        end
        // mostly short fields; some long ones to overflow the accumulator
        n_dig = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 10);
        repeat (n_dig) begin
            d = $urandom_range(0, (sb.base_code == BASE_OCT) ? 7 :
                                  (sb.base_code == BASE_HEX) ? 15 : 9);
            if (d < 10) ch = 8'(CHAR_ZERO + d);
            else ch = 8'(($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + d - 10);
            send_char(ch, 1'b0);
            items_sent++;
        end
        case ($urandom_range(0, 7))
            0: begin
                send_char(8'($urandom_range(0, 255)), 1'b1);
                items_sent++;
            end
            1: ;  // no terminator: width limit or the next field's first char ends it
            default: begin
                case ($urandom_range(0, 5))
                    0: ch = CHAR_SPACE;
                    1: ch = ",";
                    2: ch = ";";
                    3: ch = "x";
                    4: ch = "G";
                    default: ch = ")";
                endcase
                send_char(ch, 1'b0);
                items_sent++;
            end
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            items_sent++;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] width_pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: decimal, width 256; blank skip, sign, end of input cases
        send_text(" \t\n-12x");
        send_char(8'hFF, 1'b1);
        send_text("-");
        send_char(8'h00, 1'b1);
        drain();

        // hex with width limit, mixed case letters, lone minus before a non-hex letter
        write_reg(REG_NUMBER_BASE, CFG_W'(BASE_HEX));
        write_reg(REG_FIELD_WIDTH, 9'd3);
        send_text("fFa-z");
        drain();

        // unused base code and zero width
        write_reg(REG_NUMBER_BASE, 9'd3);
        write_reg(REG_FIELD_WIDTH, 9'd0);
        send_text("5");
        drain();

        // byte extremes and a letter in decimal
        write_reg(REG_NUMBER_BASE, CFG_W'(BASE_DEC));
        write_reg(REG_FIELD_WIDTH, 9'd256);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("a7");
        send_char(8'h5A, 1'b1);
        drain();

        write_reg(REG_NUMBER_BASE, CFG_W'(BASE_OCT));
        send_text("8178");
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0: width_pick = 9'd256;
                1: width_pick = 9'd511;
                2: width_pick = 9'd1;
                3: width_pick = ($urandom_range(0, 3) == 0) ? 9'd0 : 9'd2;
                default: width_pick = CFG_W'($urandom_range(1, 12));
            endcase
            if (p == 0) width_pick = 9'd256;
            if (p == 1) width_pick = 9'd1;
            write_reg(REG_FIELD_WIDTH, width_pick);
            write_reg(REG_NUMBER_BASE,
                      (p == 0) ? CFG_W'(BASE_HEX) : CFG_W'($urandom_range(0, 3)));
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0) send_field();
                else send_noise();
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_fields.size() == 0) begin
            $display("integer_field_scanner regression: pass");
        end else begin
            $display("integer_field_scanner regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ifs_pkg.sv
hw/rtl/integer_field_scanner.sv
tb/integer_field_scanner_tb.sv
